// ===== rtl/ccs_pkg.sv =====
package ccs_pkg;

  localparam int GRID_W     = 9;   // grid_width / grid_height registers
  localparam int DEC_W      = 7;
  localparam int THR_W      = 8;
  localparam int COORD_W    = 8;
  localparam int SUM_W      = 24;
  localparam int PEAK_W     = 8;
  localparam int TBL_DW     = 40;  // integral table entry
  localparam int ROW_SUM_W  = 32;
  localparam int RING_W     = 44;  // signed sum of eight corners
  localparam int S_DATA_W   = 56;
  localparam int M_DATA_W   = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int K_W        = 3;   // corner counter

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH,
    CFG_GRID_HEIGHT,
    CFG_DECIMATION,
    CFG_THRESHOLD
  } cfg_index_t;

  typedef enum logic {
    OP_LOAD,
    OP_EVAL
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_RD,
    ST_LD_WR,
    ST_EV_RD,
    ST_EV_AREA,
    ST_EV_MULA,
    ST_EV_MULB,
    ST_EV_CMP
  } state_t;

  typedef struct packed {
    logic           ld_capture;
    logic           ev_capture;
    logic           ld_rd;
    logic           ld_wr;
    logic           ev_rd;
    logic [K_W-1:0] k;
    logic           area_en;
    logic           mula_en;
    logic           mulb_en;
    logic           out_load;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } status_t;

  // corner k: bit0 picks y0, bit1 picks x0, bit2 guard window
  function automatic logic corner_neg(logic [K_W-1:0] k);
    return ^k;
  endfunction

endpackage

// ===== rtl/cfar_cell_screen.sv =====
// Cell-averaging CFAR screen over a coarse grid with a guard window.
// Load item: read the entry above, then write table and cell store; no result.
// Evaluate item: eight corner reads through the single table read port, then area,
// two multiplies and a compare into the result register.
// Reset (rst, synchronous): controller idle, load position and row sum cleared,
// registers back to 256/256/1/1; table and cell stores are not cleared.
module cfar_cell_screen #(
  parameter int MAX_GRID_WIDTH  = 256,
  parameter int MAX_GRID_HEIGHT = 256,
  parameter int OUTER_RADIUS    = 16,
  parameter int GUARD_RADIUS    = 3
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                           s_tvalid,
  output logic                           s_tready,
  // cell_x[7:0], cell_y[15:8], cell_sum[39:16], cell_peak[47:40], land_flag[48]
  input  logic [ccs_pkg::S_DATA_W-1:0]   s_tdata,
  // operation[0]: 0 load, 1 evaluate
  input  logic                           s_tuser,
  // result items
  output logic                           m_tvalid,
  input  logic                           m_tready,
  // candidate[0]
  output logic [ccs_pkg::M_DATA_W-1:0]   m_tdata
);
  import ccs_pkg::*;

  cmd_t    cmd;
  status_t status;

  // sequencer: one item in flight; a finished result waits in the
  // output register while the next item is accepted
  ccs_ctrl u_ctrl (
    .clk, .rst, .s_tvalid, .s_tuser, .s_tready, .cmd, .status
  );

  // integral table, cell store, window arithmetic, output register
  ccs_dp #(
    .MAX_GRID_WIDTH (MAX_GRID_WIDTH),
    .MAX_GRID_HEIGHT(MAX_GRID_HEIGHT),
    .OUTER_RADIUS   (OUTER_RADIUS),
    .GUARD_RADIUS   (GUARD_RADIUS)
  ) u_dp (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .s_tdata, .cmd, .status,
    .m_tvalid, .m_tready, .m_tdata
  );

  // a new result never overwrites one still waiting
  assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(m_tvalid && !m_tready))
    else $error("result overwritten");

  // table write and corner read never share a cycle
  assert property (@(posedge clk) disable iff (rst)
    !(cmd.ld_wr && cmd.ev_rd))
    else $error("table port conflict");

  // an accepted evaluate holds off the next item
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser) |=> !s_tready)
    else $error("evaluate overlapped");

  // a load produces no result
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && !s_tuser) |=> !cmd.out_load)
    else $error("load produced a result");

endmodule

// ===== rtl/ccs_ram.sv =====
module ccs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ccs_ctrl.sv =====
module ccs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  input  logic             s_tuser,
  output logic             s_tready,
  output ccs_pkg::cmd_t    cmd,
  input  ccs_pkg::status_t status
);
  import ccs_pkg::*;

  state_t         state, state_next;
  logic [K_W-1:0] k, k_next;
  logic           accept;

  assign accept = s_tvalid && (state == ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k     <= '0;
    end else begin
      state <= state_next;
      k     <= k_next;
    end
  end

  always_comb begin
    state_next = state;
    k_next     = '0;
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          state_next = (op_t'(s_tuser) == OP_EVAL) ? ST_EV_RD : ST_LD_RD;
        end
      end
      ST_LD_RD:   state_next = ST_LD_WR;
      ST_LD_WR:   state_next = ST_IDLE;
      ST_EV_RD: begin
        k_next = k + 1'b1;
        if (k == '1) begin
          state_next = ST_EV_AREA;
        end
      end
      ST_EV_AREA: state_next = ST_EV_MULA;
      ST_EV_MULA: state_next = ST_EV_MULB;
      ST_EV_MULB: state_next = ST_EV_CMP;
      ST_EV_CMP: begin
        if (!status.out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready       = (state == ST_IDLE);
    cmd            = '0;
    cmd.k          = k;
    cmd.ld_capture = accept && (op_t'(s_tuser) == OP_LOAD);
    cmd.ev_capture = accept && (op_t'(s_tuser) == OP_EVAL);
    unique case (state)
      ST_LD_RD:   cmd.ld_rd    = 1'b1;
      ST_LD_WR:   cmd.ld_wr    = 1'b1;
      ST_EV_RD:   cmd.ev_rd    = 1'b1;
      ST_EV_AREA: cmd.area_en  = 1'b1;
      ST_EV_MULA: cmd.mula_en  = 1'b1;
      ST_EV_MULB: cmd.mulb_en  = 1'b1;
      ST_EV_CMP:  cmd.out_load = !status.out_busy;
      default: ;
    endcase
  end

endmodule

// ===== rtl/ccs_dp.sv =====
module ccs_dp #(
  parameter int MAX_GRID_WIDTH  = 256,
  parameter int MAX_GRID_HEIGHT = 256,
  parameter int OUTER_RADIUS    = 16,
  parameter int GUARD_RADIUS    = 3
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [ccs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ccs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ccs_pkg::S_DATA_W-1:0]       s_tdata,
  input  ccs_pkg::cmd_t                      cmd,
  output ccs_pkg::status_t                   status,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [ccs_pkg::M_DATA_W-1:0]       m_tdata
);
  import ccs_pkg::*;

  localparam int TBL_W      = MAX_GRID_WIDTH + 1;
  localparam int TBL_DEPTH  = TBL_W * (MAX_GRID_HEIGHT + 1);
  localparam int TAW        = $clog2(TBL_DEPTH);
  localparam int CELL_DEPTH = MAX_GRID_WIDTH * MAX_GRID_HEIGHT;
  localparam int CAW        = $clog2(CELL_DEPTH);
  localparam int RMAX       = (OUTER_RADIUS > GUARD_RADIUS) ? OUTER_RADIUS : GUARD_RADIUS;
  localparam int DIM_W      = $clog2(2 * RMAX + 2);
  localparam int AREA_W     = 2 * DIM_W;
  localparam int DSQ_W      = 2 * DEC_W;
  localparam int DD_W       = AREA_W + DSQ_W;
  localparam int PROD_W     = DD_W + PEAK_W + 2;
  localparam int CMP_W      = ((PROD_W > RING_W) ? PROD_W : RING_W) + 1;
  localparam int CRD_W      = GRID_W + 1;

  // configuration
  logic [GRID_W-1:0] grid_width, grid_height, eff_w, eff_h;
  logic [DEC_W-1:0]  decimation, eff_dec;
  logic [THR_W-1:0]  threshold;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= GRID_W'(256);
      grid_height <= GRID_W'(256);
      decimation  <= DEC_W'(1);
      threshold   <= THR_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_GRID_WIDTH:  grid_width  <= cfg_data;
        CFG_GRID_HEIGHT: grid_height <= cfg_data;
        CFG_DECIMATION:  decimation  <= cfg_data[DEC_W-1:0];
        CFG_THRESHOLD:   threshold   <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    eff_w = grid_width;
    if (grid_width == '0) eff_w = GRID_W'(1);
    else if (32'(grid_width) > MAX_GRID_WIDTH) eff_w = GRID_W'(MAX_GRID_WIDTH);
    eff_h = grid_height;
    if (grid_height == '0) eff_h = GRID_W'(1);
    else if (32'(grid_height) > MAX_GRID_HEIGHT) eff_h = GRID_W'(MAX_GRID_HEIGHT);
    eff_dec = (decimation == '0) ? DEC_W'(1) : decimation;
  end

  // input fields
  logic [COORD_W-1:0] in_x, in_y;
  logic [SUM_W-1:0]   in_sum;
  logic [PEAK_W-1:0]  in_peak;
  logic               in_land;

  assign in_x    = s_tdata[7:0];
  assign in_y    = s_tdata[15:8];
  assign in_sum  = s_tdata[39:16];
  assign in_peak = s_tdata[47:40];
  assign in_land = s_tdata[48];

  function automatic logic [CRD_W-1:0] lo_edge(int v, int r);
    int m;
    m = v - r;
    if (m < 0) m = 0;
    return CRD_W'(m);
  endfunction

  function automatic logic [CRD_W-1:0] hi_edge(int v, int r, int lim);
    int m;
    m = v + r + 1;
    if (m > lim) m = lim;
    return CRD_W'(m);
  endfunction

  // memories
  logic              tbl_we, tbl_re, cell_we;
  logic [TAW-1:0]    tbl_waddr, tbl_raddr;
  logic [TBL_DW-1:0] tbl_wdata, tbl_rdata;
  logic [CAW-1:0]    cell_waddr, cell_raddr;
  logic [PEAK_W:0]   cell_wdata, cell_rdata;

  ccs_ram #(.WIDTH(TBL_DW), .DEPTH(TBL_DEPTH)) u_tbl (
    .clk, .we(tbl_we), .waddr(tbl_waddr), .wdata(tbl_wdata),
    .re(tbl_re), .raddr(tbl_raddr), .rdata(tbl_rdata)
  );

  ccs_ram #(.WIDTH(PEAK_W + 1), .DEPTH(CELL_DEPTH)) u_cell (
    .clk, .we(cell_we), .waddr(cell_waddr), .wdata(cell_wdata),
    .re(cmd.ev_capture), .raddr(cell_raddr), .rdata(cell_rdata)
  );

  // load path
  logic [GRID_W-1:0]    load_column, load_row, ld_c, ld_r, cur_c, cur_r, nc, nr;
  logic [SUM_W-1:0]     cur_sum;
  logic [PEAK_W-1:0]    cur_peak;
  logic                 cur_land;
  logic [ROW_SUM_W-1:0] row_sum;
  logic [TBL_DW-1:0]    above;

  always_comb begin
    ld_c = load_column;
    ld_r = load_row;
    if (ld_c >= eff_w) begin
      ld_c = '0;
      ld_r = load_row + 1'b1;
    end
    if (ld_r >= eff_h) ld_r = '0;
    nc = cur_c + 1'b1;
    nr = cur_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_capture) begin
      cur_c    <= ld_c;
      cur_r    <= ld_r;
      cur_sum  <= in_sum;
      cur_peak <= in_peak;
      cur_land <= in_land;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_column <= '0;
      load_row    <= '0;
      row_sum     <= '0;
    end else begin
      if (cmd.ld_rd) begin
        row_sum <= ((cur_c == '0) ? '0 : row_sum) + ROW_SUM_W'(cur_sum);
      end
      if (cmd.ld_wr) begin
        if (nc >= eff_w) begin
          load_column <= '0;
          load_row    <= (nr >= eff_h) ? '0 : nr;
        end else begin
          load_column <= nc;
          load_row    <= cur_r;
        end
      end
    end
  end

  assign above      = (cur_r == '0) ? '0 : tbl_rdata;
  assign tbl_we     = cmd.ld_wr;
  assign tbl_waddr  = TAW'((int'(cur_r) + 1) * TBL_W + int'(cur_c) + 1);
  assign tbl_wdata  = above + TBL_DW'(row_sum);
  assign cell_we    = cmd.ld_wr;
  assign cell_waddr = CAW'(int'(cur_r) * MAX_GRID_WIDTH + int'(cur_c));
  assign cell_wdata = {cur_land, cur_peak};
  assign cell_raddr = CAW'(int'(in_y) * MAX_GRID_WIDTH + int'(in_x));

  // evaluate path
  logic [CRD_W-1:0]         x0o, x1o, y0o, y1o, x0g, x1g, y0g, y1g, cx, cy;
  logic                     ev_ok, rd_pend, rd_neg, rd_zero;
  logic signed [RING_W-1:0] ring;
  logic [RING_W-1:0]        term;
  logic [AREA_W-1:0]        ao, ag;
  logic [DSQ_W-1:0]         dsq;
  logic [PEAK_W-1:0]        pk;
  logic                     pk_land, area_pos;
  logic signed [AREA_W:0]   area_s;
  logic [DD_W-1:0]          dd;
  logic signed [PROD_W-1:0] prod, diff_x, dd_x;
  logic                     cand;

  always_ff @(posedge clk) begin
    if (cmd.ev_capture) begin
      ev_ok <= (threshold != '0) && (GRID_W'(in_x) < eff_w) && (GRID_W'(in_y) < eff_h);
      x0o   <= lo_edge(int'(in_x), OUTER_RADIUS);
      y0o   <= lo_edge(int'(in_y), OUTER_RADIUS);
      x1o   <= hi_edge(int'(in_x), OUTER_RADIUS, int'(eff_w));
      y1o   <= hi_edge(int'(in_y), OUTER_RADIUS, int'(eff_h));
      x0g   <= lo_edge(int'(in_x), GUARD_RADIUS);
      y0g   <= lo_edge(int'(in_y), GUARD_RADIUS);
      x1g   <= hi_edge(int'(in_x), GUARD_RADIUS, int'(eff_w));
      y1g   <= hi_edge(int'(in_y), GUARD_RADIUS, int'(eff_h));
    end
  end

  always_comb begin
    if (cmd.k[2]) begin
      cx = cmd.k[1] ? x0g : x1g;
      cy = cmd.k[0] ? y0g : y1g;
    end else begin
      cx = cmd.k[1] ? x0o : x1o;
      cy = cmd.k[0] ? y0o : y1o;
    end
  end

  assign tbl_re    = cmd.ld_rd || cmd.ev_rd;
  assign tbl_raddr = cmd.ld_rd ? TAW'(int'(cur_r) * TBL_W + int'(cur_c) + 1)
                               : TAW'(int'(cy) * TBL_W + int'(cx));

  // corner data lands in the cycle after its address
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.ev_rd;
    end
  end

  always_ff @(posedge clk) begin
    rd_neg  <= corner_neg(cmd.k);
    rd_zero <= (cx == '0) || (cy == '0);
  end

  assign term = rd_zero ? '0 : RING_W'(tbl_rdata);

  always_ff @(posedge clk) begin
    if (cmd.ev_capture) begin
      ring <= '0;
    end else if (rd_pend) begin
      ring <= rd_neg ? ring - signed'(term) : ring + signed'(term);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.area_en) begin
      ao      <= AREA_W'(DIM_W'(x1o - x0o) * DIM_W'(y1o - y0o));
      ag      <= AREA_W'(DIM_W'(x1g - x0g) * DIM_W'(y1g - y0g));
      dsq     <= eff_dec * eff_dec;
      pk      <= cell_rdata[PEAK_W-1:0];
      pk_land <= cell_rdata[PEAK_W];
    end
    if (cmd.mula_en) begin
      area_pos <= area_s > 0;
      dd       <= DD_W'(AREA_W'(area_s) * dsq);
    end
    if (cmd.mulb_en) begin
      prod <= diff_x * dd_x;
    end
  end

  assign area_s = signed'({1'b0, ao}) - signed'({1'b0, ag});
  assign diff_x = PROD_W'(signed'({1'b0, pk}) - signed'({1'b0, threshold}));
  assign dd_x   = PROD_W'(signed'({1'b0, dd}));

  assign cand = ev_ok && (pk != '0) && !pk_land && area_pos &&
                (CMP_W'(prod) > CMP_W'(ring));

  // output register
  logic cand_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) cand_r <= cand;
  end

  assign m_tdata         = {{(M_DATA_W - 1){1'b0}}, cand_r};
  assign status.out_busy = m_tvalid && !m_tready;

endmodule
